/* src/lcmn_pkg.sv */
// Shared types and constants for the light-change to MIDI note block.
// No dependencies; imported by lcmn_front, lcmn_back, the top level and the testbench.
package lcmn_pkg;

   // Width of one light bank and of the packed input bank word.
   localparam int BANK_W      = 16;
   localparam int BANKS_W     = 4 * BANK_W;

   // Widths of the MIDI fields.
   localparam int NOTE_W      = 7;
   localparam int VEL_W       = 7;
   localparam int CHAN_W      = 5;

   // Input action codes.
   localparam logic ACTION_UPDATE  = 1'b0;
   localparam logic ACTION_ALL_OFF = 1'b1;

   // Configuration register indexes (word address bits).
   localparam int            REG_IDX_W       = 2;
   localparam logic [1:0]    REG_NOTE_OFFSET = 2'd0;
   localparam logic [1:0]    REG_VELOCITY    = 2'd1;
   localparam logic [1:0]    REG_CHANNEL     = 2'd2;

   // Register reset values.
   localparam logic [NOTE_W-1:0] RST_NOTE_OFFSET = 7'd0;
   localparam logic [VEL_W-1:0]  RST_VELOCITY    = 7'd127;
   localparam logic [CHAN_W-1:0] RST_CHANNEL     = 5'd1;

   // Configuration seen by the event generator.
   typedef struct packed {
      logic [NOTE_W-1:0] note_offset;
      logic [VEL_W-1:0]  note_velocity;
      logic [CHAN_W-1:0] midi_channel;
   } cfg_type;

   // The status nibble only holds channels 1 to 16, so out-of-range values wrap.
   function automatic logic [CHAN_W-1:0] event_chan(input logic [CHAN_W-1:0] chan);
      logic [3:0] nibble;
      nibble = 4'(chan - 5'd1);
      return {1'b0, nibble} + 5'd1;
   endfunction

endpackage

/* src/lcmn_queue.sv */
// Two-entry job queue between the front classifier and the event generator.
// Depends on nothing but its WIDTH parameter.
module lcmn_queue #(
   parameter int WIDTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/lcmn_front.sv */
// Front end: accepts light beats, compares with the stored light state and
// builds note-off and note-on masks. Depends on lcmn_pkg.
module lcmn_front
   import lcmn_pkg::*;
#(
   parameter int NUM_LIGHTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BANKS_W-1:0]    req_tdata,
   input  logic                  req_tuser,
   input  logic                  queue_full,
   output logic                  push,
   output logic [NUM_LIGHTS-1:0] push_off,
   output logic [NUM_LIGHTS-1:0] push_on
);

   logic [NUM_LIGHTS-1:0] prev_ff, prev_in;
   logic [NUM_LIGHTS-1:0] now_lights;
   logic [NUM_LIGHTS-1:0] changed;
   logic                  accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign now_lights = req_tdata[NUM_LIGHTS-1:0];
   assign changed    = now_lights ^ prev_ff;

   // Classify the beat into the masks of lights to switch off and on.
   always_comb begin
      prev_in  = prev_ff;
      push     = 1'b0;
      push_off = changed & ~now_lights;
      push_on  = changed & now_lights;
      if (accept) begin
         if (req_tuser == ACTION_ALL_OFF) begin
            push     = 1'b1;
            push_off = '1;
            push_on  = '0;
         end else begin
            // An update without any change produces no job at all.
            push    = (changed != '0);
            prev_in = now_lights;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

/* src/lcmn_back.sv */
// Back end: walks the masks of one job a light per cycle unless a stalled output holds
// it, and emits MIDI events into the output register. Depends on lcmn_pkg.
module lcmn_back
   import lcmn_pkg::*;
#(
   parameter int NUM_LIGHTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  queue_empty,
   input  logic [NUM_LIGHTS-1:0] job_off,
   input  logic [NUM_LIGHTS-1:0] job_on,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W = $clog2(NUM_LIGHTS);

   localparam logic PHASE_OFF = 1'b0;
   localparam logic PHASE_ON  = 1'b1;

   logic                  busy_ff, busy_in;
   logic                  phase_ff, phase_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [NUM_LIGHTS-1:0] off_ff, off_in;
   logic [NUM_LIGHTS-1:0] on_ff, on_in;
   logic [NUM_LIGHTS-1:0] rest_off, rest_on;
   logic                  cur_bit, can_emit, step, emit, last;

   logic                  valid_ff, valid_in;
   logic                  is_on_ff;
   logic                  last_ff;
   logic [NOTE_W-1:0]     note_ff;
   logic [VEL_W-1:0]      vel_ff;
   logic [CHAN_W-1:0]     chan_ff;

   assign rest_off = off_ff >> 1;
   assign rest_on  = on_ff >> 1;
   assign cur_bit  = (phase_ff == PHASE_ON) ? on_ff[0] : off_ff[0];
   assign can_emit = !valid_ff || rsp_tready;
   assign step     = busy_ff && (!cur_bit || can_emit);
   assign emit     = busy_ff && cur_bit && can_emit;
   assign last     = (phase_ff == PHASE_ON) ? (rest_on == '0)
                                            : ((rest_off == '0) && (on_ff == '0));
   assign pop      = !busy_ff && !queue_empty;

   // Sequencer: off pass over the off mask, then on pass over the on mask.
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      off_in   = off_ff;
      on_in    = on_ff;
      if (pop) begin
         busy_in  = 1'b1;
         phase_in = (job_off == '0) ? PHASE_ON : PHASE_OFF;
         idx_in   = '0;
         off_in   = job_off;
         on_in    = job_on;
      end else if (step) begin
         if (phase_ff == PHASE_OFF) begin
            off_in = rest_off;
            if (rest_off == '0) begin
               phase_in = PHASE_ON;
               idx_in   = '0;
               busy_in  = (on_ff != '0);
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end else begin
            on_in = rest_on;
            if (rest_on == '0) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PHASE_OFF;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      on_ff  <= on_in;
   end

   // Output register holds one event beat until the receiver takes it.
   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         is_on_ff <= (phase_ff == PHASE_ON);
         last_ff  <= last;
         note_ff  <= cfg.note_offset + NOTE_W'(idx_ff);
         vel_ff   <= (phase_ff == PHASE_ON) ? cfg.note_velocity : '0;
         chan_ff  <= event_chan(cfg.midi_channel);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = is_on_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'd0, chan_ff, vel_ff, note_ff};

endmodule

/* src/light_change_to_midi_notes.sv */
// Light-change to MIDI note event generator, top level with register port.
// Depends on lcmn_pkg, lcmn_front, lcmn_queue and lcmn_back.
//
// Usage: the req_ channel takes one beat per light snapshot (tdata holds the
// four 16-bit banks, tuser selects update or all-notes-off). The rsp_ channel
// gives one beat per MIDI event: note-offs for lights that went dark, then
// note-ons for lights that came on, each in ascending light order; tlast
// marks the final event of a snapshot. An update with no change gives none.
// The front accepts a beat whenever the queue is not full and queues up to
// two jobs; the back scans one light per cycle unless a stalled output holds
// it at a light with an event, and a job ends after its last event. An
// accepted snapshot passes through the queue, the scanner registers and the
// output register before its first event appears, later still for every
// light scanned ahead of it.
// When the receiver stalls, the event waits in the output register and the
// scan holds at its next event; the front accepts until the queue is full.
// Reset clears the stored light state, the queue and the registers to
// offset 0, velocity 127, channel 1. Write registers only while idle.
module light_change_to_midi_notes
   import lcmn_pkg::*;
#(
   parameter int NUM_LIGHTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Input beat.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // bank_zero, bank_one, bank_two, bank_three
   input  logic        req_tuser,   // action
   // Event beat.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // note_number, event_velocity, event_channel
   output logic        rsp_tuser,   // is_note_on
   output logic        rsp_tlast,   // last_event
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type               cfg_ff, cfg_in;
   logic                  wr_en;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  push, pop, q_full, q_empty;
   logic [NUM_LIGHTS-1:0] push_off, push_on, job_off, job_on;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_NOTE_OFFSET: cfg_in.note_offset   = csr_pwdata[NOTE_W-1:0];
            REG_VELOCITY:    cfg_in.note_velocity = csr_pwdata[VEL_W-1:0];
            REG_CHANNEL:     cfg_in.midi_channel  = csr_pwdata[CHAN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.note_offset   <= RST_NOTE_OFFSET;
         cfg_ff.note_velocity <= RST_VELOCITY;
         cfg_ff.midi_channel  <= RST_CHANNEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read decode.
   always_comb begin
      unique case (reg_idx)
         REG_NOTE_OFFSET: csr_prdata = 32'(cfg_ff.note_offset);
         REG_VELOCITY:    csr_prdata = 32'(cfg_ff.note_velocity);
         REG_CHANNEL:     csr_prdata = 32'(cfg_ff.midi_channel);
         default:         csr_prdata = 32'd0;
      endcase
   end

   lcmn_front #(.NUM_LIGHTS(NUM_LIGHTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (q_full),
      .push       (push),
      .push_off   (push_off),
      .push_on    (push_on)
   );

   lcmn_queue #(.WIDTH(2 * NUM_LIGHTS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_on, push_off}),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .pop_data  ({job_on, job_off})
   );

   lcmn_back #(.NUM_LIGHTS(NUM_LIGHTS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (q_empty),
      .job_off     (job_off),
      .job_on      (job_on),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* src/lcmn_checker.sv */
// Port-level checks for the light-change to MIDI note block.
// Depends on the top level's ports only; bound to it below.
module lcmn_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast
);

   // A stalled event beat stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("event beat dropped while stalled");

   // A stalled event beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("event beat changed while stalled");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("event beat valid after reset");

   // Note-off events carry zero velocity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[13:7] == 7'd0)
      else $error("note-off with nonzero velocity");

   // The event channel always lies between 1 and 16.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:14] != 5'd0) && (rsp_tdata[18:14] <= 5'd16))
      else $error("event channel out of range");

endmodule

bind light_change_to_midi_notes lcmn_checker u_checker (.*);

/* tb/light_change_to_midi_notes_test.sv */
// Self-checking testbench for the light-change to MIDI note event generator.
// Drives light snapshots and register writes, predicts every event beat and checks it.
// Depends on lcmn_pkg and light_change_to_midi_notes.
`timescale 1ns / 100ps

module light_change_to_midi_notes_test
   import lcmn_pkg::*;
;

   localparam int LIGHTS        = 64;
   // Room for up to two queued jobs plus one in the scanner to finish.
   localparam int SETTLE_CYCLES = 450;
   localparam int IDLE_LIMIT    = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 250;
   localparam int RANDOM_PHASES = 5;

   typedef struct packed {
      logic              on;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  vel;
      logic [CHAN_W-1:0] chan;
      logic              last;
   } midi_note_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;
   logic        req_tuser   = ACTION_UPDATE;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the block: stored lights and register settings.
   logic [63:0]       lights_held;
   logic [NOTE_W-1:0] cfg_offset;
   logic [VEL_W-1:0]  cfg_velocity;
   logic [CHAN_W-1:0] cfg_channel;
   midi_note_type     expected_notes[$];
   int                mismatches     = 0;
   bit                quiet_sender   = 1'b0;
   bit                quiet_receiver = 1'b0;
   bit                hold_request   = 1'b0;

   light_change_to_midi_notes #(.NUM_LIGHTS(LIGHTS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Gap lengths: mostly none, some short, a few long.
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(10, 60);
   endfunction

   // Work out the events one snapshot causes and queue them in order.
   function automatic void predict_notes(input logic action, input logic [63:0] banks);
      logic [63:0]       changed;
      logic [CHAN_W-1:0] chan_less_one;
      logic [CHAN_W-1:0] chan;
      int                total;
      int                k;
      bit                hit;
      midi_note_type     ev;
      // The status nibble holds channel minus one, so the channel wraps mod 16.
      chan_less_one = cfg_channel + 5'd15;
      chan          = {1'b0, chan_less_one[3:0]} + 5'd1;
      changed       = banks ^ lights_held;
      total         = (action == ACTION_ALL_OFF) ? LIGHTS : $countones(changed);
      k             = 0;
      // First pass gives the note-offs, second pass the note-ons.
      for (int pass = 0; pass < 2; pass++) begin
         for (int i = 0; i < LIGHTS; i++) begin
            if (action == ACTION_ALL_OFF) hit = (pass == 0);
            else hit = changed[i] && (banks[i] == (pass == 1));
            if (hit) begin
               ev.on   = (pass == 1);
               ev.note = NOTE_W'(i + cfg_offset);
               ev.vel  = (pass == 1) ? cfg_velocity : '0;
               ev.chan = chan;
               ev.last = (k == total - 1);
               expected_notes.push_back(ev);
               k++;
            end
         end
      end
      if (action == ACTION_UPDATE) lights_held = banks;
   endfunction

   // Offer one snapshot beat and wait until it is taken. Called at a rising edge.
   task automatic send_lights(input logic action, input logic [63:0] banks);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= banks;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_notes(action, banks);
      gap = pick_gap(quiet_sender);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every expected event, then let the scanner finish.
   task automatic drain_events();
      req_tvalid <= 1'b0;
      while (expected_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back. Only called while the block is idle.
   task automatic configure(input logic [NOTE_W-1:0] offset, input logic [VEL_W-1:0] velocity,
                            input logic [CHAN_W-1:0] channel);
      logic [REG_IDX_W-1:0] regs [3];
      logic [31:0]          values [3];
      regs[0]   = REG_NOTE_OFFSET;
      regs[1]   = REG_VELOCITY;
      regs[2]   = REG_CHANNEL;
      values[0] = 32'(offset);
      values[1] = 32'(velocity);
      values[2] = 32'(channel);
      for (int r = 0; r < 3; r++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {regs[r], 2'b00};
         csr_pwdata  <= values[r];
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_offset   = offset;
      cfg_velocity = velocity;
      cfg_channel  = channel;
   endtask

   task automatic flag_mismatch(input string what, input midi_note_type want,
                                input midi_note_type seen);
      mismatches++;
      if (mismatches <= 10)
         $display({"%s: expected on=%0b note=%0d vel=%0d ch=%0d last=%0b, ",
                   "got on=%0b note=%0d vel=%0d ch=%0d last=%0b"},
                  what, want.on, want.note, want.vel, want.chan, want.last,
                  seen.on, seen.note, seen.vel, seen.chan, seen.last);
   endtask

   // Compare every event beat with the oldest expectation.
   always @(posedge clock) begin : check_events
      midi_note_type seen;
      midi_note_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.on   = rsp_tuser;
         seen.note = rsp_tdata[6:0];
         seen.vel  = rsp_tdata[13:7];
         seen.chan = rsp_tdata[18:14];
         seen.last = rsp_tlast;
         if (expected_notes.size() == 0) begin
            flag_mismatch("event beat with nothing expected", '0, seen);
         end else begin
            want = expected_notes.pop_front();
            if (seen.on != want.on || seen.note != want.note || seen.vel != want.vel ||
                seen.chan != want.chan || seen.last != want.last || rsp_tdata[23:19] != '0)
               flag_mismatch("event beat mismatch", want, seen);
         end
      end
   end

   // Receiver: random stalls, and one long hold-off on request.
   initial begin : event_receiver
      int stall;
      int hold;
      stall = 0;
      hold  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold         = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet_receiver && $urandom_range(0, 99) < 20) stall = pick_gap(1'b0);
         end
      end
   end

   // Watchdog: too long without any beat or register access ends the run.
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
            idle = 0;
         else
            idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("light_change_to_midi_notes_test NOT OK");
            $finish;
         end
      end
   end

   // Extremes of the banks, both actions and the no-change case, at reset settings.
   task automatic test_directed_lights();
      send_lights(ACTION_UPDATE, '0);
      send_lights(ACTION_UPDATE, '1);
      send_lights(ACTION_UPDATE, '1);
      send_lights(ACTION_ALL_OFF, '0);
      send_lights(ACTION_UPDATE, '0);
      send_lights(ACTION_UPDATE, 64'h0000_0000_0000_0001);
      send_lights(ACTION_UPDATE, 64'h8000_0000_0000_0000);
      send_lights(ACTION_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_lights(ACTION_UPDATE, 64'h5555_5555_5555_5555);
      // Lights on both sides of every bank boundary.
      send_lights(ACTION_UPDATE, 64'h0001_8001_8001_8000);
      // Bank data must be ignored on all-notes-off.
      send_lights(ACTION_ALL_OFF, {$urandom, $urandom});
      send_lights(ACTION_UPDATE, 64'hFFFF_0000_FFFF_0000);
   endtask

   // Note numbers that wrap past 127 and channels outside 1 to 16.
   task automatic test_note_wrap_and_channel();
      drain_events();
      configure(7'd127, 7'd0, 5'd0);
      send_lights(ACTION_UPDATE, '1);
      send_lights(ACTION_ALL_OFF, '0);
      send_lights(ACTION_UPDATE, '0);
      drain_events();
      configure(7'd64, 7'd1, 5'd17);
      send_lights(ACTION_UPDATE, 64'h8000_0000_0000_0001);
      send_lights(ACTION_ALL_OFF, '1);
      send_lights(ACTION_UPDATE, '0);
      drain_events();
      configure(7'd1, 7'd127, 5'd31);
      send_lights(ACTION_UPDATE, '1);
      send_lights(ACTION_UPDATE, '0);
   endtask

   // Mostly a few lights toggling per snapshot, with full random patterns,
   // repeats and all-notes-off mixed in.
   task automatic test_random_lights(input int count);
      logic [63:0] banks;
      int          r;
      int          flips;
      repeat (count) begin
         r     = $urandom_range(0, 99);
         banks = lights_held;
         if (r < 10) begin
            send_lights(ACTION_ALL_OFF, {$urandom, $urandom});
         end else begin
            if (r < 25) begin
               banks = {$urandom, $urandom};
            end else if (r >= 30) begin
               flips = $urandom_range(1, 6);
               repeat (flips) banks = banks ^ (64'd1 << $urandom_range(0, LIGHTS - 1));
            end
            send_lights(ACTION_UPDATE, banks);
         end
      end
   endtask

   // Receiver holds off long enough for the job queue to fill and stall the input.
   task automatic test_input_backpressure();
      drain_events();
      configure(7'($urandom_range(0, 64)), 7'($urandom_range(0, 127)),
                5'($urandom_range(1, 16)));
      quiet_sender = 1'b1;
      hold_request = 1'b1;
      repeat (4) begin
         send_lights(ACTION_UPDATE, '1);
         send_lights(ACTION_UPDATE, '0);
      end
      quiet_sender = 1'b0;
   endtask

   initial begin
      lights_held  = '0;
      cfg_offset   = RST_NOTE_OFFSET;
      cfg_velocity = RST_VELOCITY;
      cfg_channel  = RST_CHANNEL;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_lights();
      test_note_wrap_and_channel();

      // Random snapshots under several register settings; one phase runs without gaps.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_events();
         case (phase)
            0: configure(RST_NOTE_OFFSET, RST_VELOCITY, RST_CHANNEL);
            1: configure(7'd64, 7'd0, 5'd16);
            2: configure(7'($urandom_range(0, 64)), 7'($urandom_range(0, 127)),
                         5'($urandom_range(1, 16)));
            3: configure(7'd127, 7'd1, 5'd17);
            default: configure(7'($urandom), 7'($urandom), 5'($urandom));
         endcase
         quiet_sender   = (phase == 2);
         quiet_receiver = (phase == 2);
         test_random_lights(RANDOM_ITEMS / RANDOM_PHASES);
      end
      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;

      test_input_backpressure();

      drain_events();
      if (mismatches == 0 && expected_notes.size() == 0)
         $display("light_change_to_midi_notes_test OK");
      else
         $display("light_change_to_midi_notes_test NOT OK");
      $finish;
   end

endmodule
